// ----- src/dupw_pkg.sv -----
package dupw_pkg;

  localparam int ACC_W   = 51;  // exact dot product width
  localparam int QBITS   = 34;  // quotient bits resolved by the cell row
  localparam int NREG    = 8;
  localparam int IDX_W   = 4;
  localparam int CFG_W   = 64;
  localparam int COEF_W  = 32;
  localparam int OPND_W  = 17;  // Q.16 operand of the dot product
  localparam int PROD_W  = COEF_W + OPND_W;

  localparam logic [CFG_W-1:0] REG_RESET [NREG] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [QBITS-1:0] dlo;
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             over;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]      lane;
    logic [ACC_W-1:0] den;
    logic             clip;
  } cell_t;

endpackage

// ----- src/dupw_if.sv -----
interface dupw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ndc_x;
  logic [15:0] ndc_y;
  logic [15:0] depth;
  modport source (output valid, ndc_x, ndc_y, depth, input ready);
  modport sink (input valid, ndc_x, ndc_y, depth, output ready);
endinterface

interface dupw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] world_x;
  logic [31:0] world_y;
  logic [31:0] world_z;
  logic        clipped;
  modport source (output valid, world_x, world_y, world_z, clipped, input ready);
  modport sink (input valid, world_x, world_y, world_z, clipped, output ready);
endinterface

// ----- src/dupw_cell.sv -----
module dupw_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  input  dupw_pkg::cell_t      d,
  output logic                 vout,
  output dupw_pkg::cell_t      q
);

  dupw_pkg::cell_t nxt;

  // One restoring step per lane: shift in the next dividend bit and subtract.
  always_comb begin
    logic [dupw_pkg::ACC_W:0] r2;
    logic                     bit_q;
    nxt = d;
    for (int i = 0; i < 3; i++) begin
      r2 = {d.lane[i].rem, d.lane[i].dlo[dupw_pkg::QBITS-1]};
      bit_q = (r2 >= {1'b0, d.den});
      if (bit_q) begin
        r2 = r2 - {1'b0, d.den};
      end
      nxt.lane[i].rem = r2[dupw_pkg::ACC_W-1:0];
      nxt.lane[i].dlo = {d.lane[i].dlo[dupw_pkg::QBITS-2:0], 1'b0};
      nxt.lane[i].quo = {d.lane[i].quo[dupw_pkg::QBITS-2:0], bit_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ----- src/depth_unproject_to_world_top.sv -----
// Registers in order: products, row sums, the head of the cell row, each cell, and the output.
// Throughput: one transaction per cycle; the pipeline stalls as a whole only
// while a finished result waits at the output.
// The divide is a row of 34 restoring cells, one quotient bit per cell.
// Reset clears all valid flags and loads the identity matrix.
module depth_unproject_to_world_top #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  dupw_in_if.sink                      pix,
  dupw_out_if.source                   res,
  input  logic                         cfg_we,
  input  logic [dupw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dupw_pkg::CFG_W-1:0]   cfg_data
);

  localparam int F = COORD_FRAC_BITS;
  localparam int AW = dupw_pkg::ACC_W;
  localparam int QB = dupw_pkg::QBITS;
  localparam int PW = dupw_pkg::PROD_W;

  logic [dupw_pkg::CFG_W-1:0] mtx [dupw_pkg::NREG];
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dupw_pkg::NREG; i++) begin
        mtx[i] <= dupw_pkg::REG_RESET[i];
      end
    end else if (cfg_we && cfg_index < dupw_pkg::IDX_W'(dupw_pkg::NREG)) begin
      mtx[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign en = !res.valid || res.ready;
  assign pix.ready = en;

  // Operands in Q.16.
  logic signed [dupw_pkg::OPND_W-1:0] opx, opy, opz;
  assign opx = {pix.ndc_x, 1'b0};
  assign opy = {pix.ndc_y, 1'b0};
  assign opz = {pix.depth, 1'b0} - 17'd65536;

  // Stage 1: products.
  logic v1;
  logic signed [dupw_pkg::PROD_W-1:0] prod [4][3];
  logic signed [dupw_pkg::COEF_W-1:0] cst [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pix.valid;
    end
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= PW'($signed(mtx[2*r][31:0])) * PW'(opx);
        prod[r][1] <= PW'($signed(mtx[2*r][63:32])) * PW'(opy);
        prod[r][2] <= PW'($signed(mtx[2*r+1][31:0])) * PW'(opz);
        cst[r]     <= $signed(mtx[2*r+1][63:32]);
      end
    end
  end

  // Stage 2: row sums.
  logic v2;
  logic signed [AW-1:0] acc [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        acc[r] <= AW'(prod[r][0]) + AW'(prod[r][1]) + AW'(prod[r][2])
                + (AW'(cst[r]) <<< 16);
      end
    end
  end

  // Stage 3: magnitudes, zero-w fix and the upper part of each quotient.
  dupw_pkg::cell_t head;
  logic            v3;

  always_comb begin
    logic [AW-1:0]   uw;
    logic [AW-1:0]   mg;
    logic [AW+F-1:0] dtot;
    logic            wz;
    wz = (acc[3] == '0);
    uw = wz ? AW'(1) : (acc[3][AW-1] ? AW'(-acc[3]) : AW'(acc[3]));
    head.den  = uw;
    head.clip = wz;
    for (int i = 0; i < 3; i++) begin
      mg = acc[i][AW-1] ? AW'(-acc[i]) : AW'(acc[i]);
      dtot = {mg, {F{1'b0}}};
      head.lane[i].rem  = AW'(dtot[AW+F-1:QB]);
      head.lane[i].dlo  = dtot[QB-1:0];
      head.lane[i].quo  = '0;
      head.lane[i].neg  = acc[i][AW-1] ^ acc[3][AW-1];
      head.lane[i].over = (AW'(dtot[AW+F-1:QB]) >= uw);
    end
  end

  dupw_pkg::cell_t chain [QB+1];
  logic            vch [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      chain[0] <= head;
    end
  end
  assign vch[0] = v3;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    dupw_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (vch[k]),
      .d    (chain[k]),
      .vout (vch[k+1]),
      .q    (chain[k+1])
    );
  end

  // Sign and saturation, then the output register.
  logic [31:0] wv [3];
  logic [2:0]  sat;

  always_comb begin
    dupw_pkg::lane_t ln;
    logic [QB-1:0]   nq;
    for (int i = 0; i < 3; i++) begin
      ln = chain[QB].lane[i];
      nq = '0 - ln.quo;
      if (!ln.neg) begin
        sat[i] = ln.over || (ln.quo > QB'(32'h7FFFFFFF));
        wv[i]  = sat[i] ? 32'h7FFFFFFF : ln.quo[31:0];
      end else begin
        sat[i] = ln.over || (ln.quo > QB'(32'h80000000));
        wv[i]  = sat[i] ? 32'h80000000 : nq[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= vch[QB];
    end
    if (en) begin
      res.world_x <= wv[0];
      res.world_y <= wv[1];
      res.world_z <= wv[2];
      res.clipped <= chain[QB].clip || (|sat);
    end
  end

endmodule
